// ===== src/pid_pkg.sv =====
`default_nettype none

package pid_pkg;

   localparam int VALUE_W     = 32;
   localparam int STEP_W      = 24;
   localparam int INTEGRAL_W  = 48;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 48;

   localparam bit ERROR_FOLD_DEFAULT = 1'b0;

   // Pi and two pi in Q16.16, sized for the widened error.
   localparam logic signed [33:0] PI_Q16     = 34'sd205887;
   localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

   // Radix-4 divider: two quotient bits per cycle over a 64-bit dividend.
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SUBTRACT,
      ST_FOLD,
      ST_CLIP,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_PTERM,
      ST_ISUM,
      ST_ICLAMP,
      ST_ITERM,
      ST_DPREP,
      ST_DIV,
      ST_DSIGN,
      ST_SUM_PI,
      ST_SUM_D,
      ST_BIAS,
      ST_DCLAMP,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MOP_P_HI,
      MOP_P_LO,
      MOP_I_DT,
      MOP_K_HI,
      MOP_K_MID,
      MOP_K_LO,
      MOP_D_HI,
      MOP_D_LO
   } mul_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_INT_FLOOR,
      CSR_INT_CEILING,
      CSR_DRIVE_FLOOR,
      CSR_DRIVE_CEILING,
      CSR_DRIVE_BIAS
   } csr_index_type;

endpackage

`default_nettype wire

// ===== src/pid_req_if.sv =====
`default_nettype none

interface pid_req_if;
   import pid_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] target_value;
   logic signed [VALUE_W-1:0] measured_value;
   logic [STEP_W-1:0]         time_step;

   modport source (output valid, output target_value, output measured_value,
                   output time_step, input ready);
   modport sink (input valid, input target_value, input measured_value,
                 input time_step, output ready);
endinterface

`default_nettype wire

// ===== src/pid_rsp_if.sv =====
`default_nettype none

interface pid_rsp_if;
   import pid_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] drive;
   logic signed [VALUE_W-1:0] error_out;

   modport source (output valid, output drive, output error_out, input ready);
   modport sink (input valid, input drive, input error_out, output ready);
endinterface

`default_nettype wire

// ===== src/pid_csr_if.sv =====
`default_nettype none

interface pid_csr_if;
   import pid_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/pid_controller_step.sv =====
// Requests run one at a time: a new request is accepted only in idle, once the
// previous result is in the output register. The sequencer runs eight passes
// through the shared 33x25 multiplier and 32 steps of the radix-4 divider.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active high) clears all configuration registers, the
// integral sum and the last error, and returns the sequencer to idle.
`default_nettype none

module pid_controller_step #(
   parameter bit ERROR_FOLD = pid_pkg::ERROR_FOLD_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   pid_req_if.sink    req_bus,
   pid_rsp_if.source  rsp_bus,
   pid_csr_if.sink    csr_bus
);
   import pid_pkg::*;

   localparam logic signed [33:0] E_MAX = 34'sd2147483647;
   localparam logic signed [33:0] E_MIN = -34'sd2147483648;
   localparam logic signed [63:0] W_MAX = 64'sd2147483647;
   localparam logic signed [63:0] W_MIN = -64'sd2147483648;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         sat_add64 = $signed(s[63:0]);
      end
   endfunction

   function automatic logic signed [31:0] sat_to32(input logic signed [63:0] x);
      if (x > W_MAX) begin
         sat_to32 = 32'sh7FFF_FFFF;
      end else if (x < W_MIN) begin
         sat_to32 = $signed(32'h8000_0000);
      end else begin
         sat_to32 = $signed(x[31:0]);
      end
   endfunction

   // Control and architectural state.
   state_type   state_ff, state_in;
   mul_op_type  mop_ff, mop_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] kp_ff, ki_ff, kd_ff;
   logic signed [47:0] ifloor_ff, iceil_ff;
   logic signed [31:0] dfloor_ff, dceil_ff, bias_ff;
   logic signed [47:0] isum_ff, isum_in;
   logic signed [31:0] last_ff, last_in;

   // Datapath registers.
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] measured_ff, measured_in;
   logic [23:0]        dt_ff, dt_in;
   logic signed [33:0] eraw_ff, eraw_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [32:0] diff_ff, diff_in;
   logic signed [57:0] prod_ff, prod_in;
   logic [79:0]        acc_ff, acc_in;
   logic signed [47:0] p_ff, p_in;
   logic signed [63:0] iterm_ff, iterm_in;
   logic [63:0]        quo_ff, quo_in;
   logic [23:0]        rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [31:0] drive_ff, drive_in;
   logic signed [31:0] eout_ff, eout_in;

   // Shared multiplier operands.
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;

   // Two restoring division steps per cycle.
   logic [24:0] t1, t2;
   logic        ge1, ge2;
   logic [23:0] r1, r2;
   logic [63:0] q1, q2;

   assign t1  = {rem_ff, quo_ff[63]};
   assign ge1 = t1 >= {1'b0, dt_ff};
   assign r1  = ge1 ? 24'(t1 - {1'b0, dt_ff}) : t1[23:0];
   assign q1  = {quo_ff[62:0], ge1};
   assign t2  = {r1, q1[63]};
   assign ge2 = t2 >= {1'b0, dt_ff};
   assign r2  = ge2 ? 24'(t2 - {1'b0, dt_ff}) : t2[23:0];
   assign q2  = {q1[62:0], ge2};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mop_ff)
         MOP_P_HI: begin
            mul_a = {kp_ff[31], kp_ff};
            mul_b = $signed({{9{e_ff[31]}}, e_ff[31:16]});
         end
         MOP_P_LO: begin
            mul_a = {kp_ff[31], kp_ff};
            mul_b = $signed({9'd0, e_ff[15:0]});
         end
         MOP_I_DT: begin
            mul_a = {e_ff[31], e_ff};
            mul_b = $signed({1'b0, dt_ff});
         end
         MOP_K_HI: begin
            mul_a = {ki_ff[31], ki_ff};
            mul_b = $signed({{9{isum_ff[47]}}, isum_ff[47:32]});
         end
         MOP_K_MID: begin
            mul_a = {ki_ff[31], ki_ff};
            mul_b = $signed({9'd0, isum_ff[31:16]});
         end
         MOP_K_LO: begin
            mul_a = {ki_ff[31], ki_ff};
            mul_b = $signed({9'd0, isum_ff[15:0]});
         end
         MOP_D_HI: begin
            mul_a = {kd_ff[31], kd_ff};
            mul_b = $signed({{8{diff_ff[32]}}, diff_ff[32:16]});
         end
         MOP_D_LO: begin
            mul_a = {kd_ff[31], kd_ff};
            mul_b = $signed({9'd0, diff_ff[15:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      logic [79:0]        pe;
      logic [79:0]        shifted;
      logic [48:0]        s49;
      logic signed [63:0] bias64;
      logic signed [63:0] dfl64;
      logic signed [63:0] dce64;

      state_in     = state_ff;
      mop_in       = mop_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      isum_in      = isum_ff;
      last_in      = last_ff;
      target_in    = target_ff;
      measured_in  = measured_ff;
      dt_in        = dt_ff;
      eraw_in      = eraw_ff;
      e_in         = e_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      iterm_in     = iterm_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      sum_in       = sum_ff;
      drive_in     = drive_ff;
      eout_in      = eout_ff;

      pe      = {{22{prod_ff[57]}}, prod_ff};
      shifted = pe;
      s49     = {isum_ff[47], isum_ff} + {{9{acc_ff[55]}}, acc_ff[55:16]};
      bias64  = {{32{bias_ff[31]}}, bias_ff};
      dfl64   = {{32{dfloor_ff[31]}}, dfloor_ff};
      dce64   = {{32{dceil_ff[31]}}, dceil_ff};

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               target_in   = req_bus.target_value;
               measured_in = req_bus.measured_value;
               dt_in       = req_bus.time_step;
               state_in    = ST_SUBTRACT;
            end
         end
         ST_SUBTRACT: begin
            eraw_in  = {measured_ff[31], measured_ff[31], measured_ff}
                     - {target_ff[31], target_ff[31], target_ff};
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (ERROR_FOLD) begin
               if (eraw_ff > PI_Q16) begin
                  eraw_in = eraw_ff - TWO_PI_Q16;
               end else if (eraw_ff < -PI_Q16) begin
                  eraw_in = eraw_ff + TWO_PI_Q16;
               end
            end
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            if (eraw_ff > E_MAX) begin
               e_in = 32'sh7FFF_FFFF;
            end else if (eraw_ff < E_MIN) begin
               e_in = $signed(32'h8000_0000);
            end else begin
               e_in = $signed(eraw_ff[31:0]);
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = {e_ff[31], e_ff} - {last_ff[31], last_ff};
            last_in  = e_ff;
            mop_in   = MOP_P_HI;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            case (mop_ff)
               MOP_P_HI, MOP_K_MID, MOP_D_HI: shifted = {pe[63:0], 16'd0};
               MOP_K_HI:                      shifted = {pe[47:0], 32'd0};
               default:                       shifted = pe;
            endcase
            if (mop_ff == MOP_P_HI || mop_ff == MOP_I_DT || mop_ff == MOP_K_HI ||
                mop_ff == MOP_D_HI) begin
               acc_in = shifted;
            end else begin
               acc_in = acc_ff + shifted;
            end
            case (mop_ff)
               MOP_P_LO: state_in = ST_PTERM;
               MOP_I_DT: state_in = ST_ISUM;
               MOP_K_LO: state_in = ST_ITERM;
               MOP_D_LO: state_in = ST_DPREP;
               default: begin
                  mop_in   = mul_op_type'(mop_ff + 3'd1);
                  state_in = ST_MUL;
               end
            endcase
         end
         ST_PTERM: begin
            p_in     = $signed(acc_ff[63:16]);
            mop_in   = mul_op_type'(mop_ff + 3'd1);
            state_in = ST_MUL;
         end
         ST_ISUM: begin
            if (s49[48] != s49[47]) begin
               isum_in = s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
               isum_in = $signed(s49[47:0]);
            end
            state_in = ST_ICLAMP;
         end
         ST_ICLAMP: begin
            if (ifloor_ff < iceil_ff) begin
               if (isum_ff < ifloor_ff) begin
                  isum_in = ifloor_ff;
               end else if (isum_ff > iceil_ff) begin
                  isum_in = iceil_ff;
               end
            end
            mop_in   = mul_op_type'(mop_ff + 3'd1);
            state_in = ST_MUL;
         end
         ST_ITERM: begin
            iterm_in = $signed(acc_ff[79:16]);
            mop_in   = mul_op_type'(mop_ff + 3'd1);
            state_in = ST_MUL;
         end
         ST_DPREP: begin
            neg_in   = acc_ff[63];
            quo_in   = acc_ff[63] ? 64'd0 - acc_ff[63:0] : acc_ff[63:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = r2;
            quo_in = q2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DSIGN;
            end
         end
         ST_DSIGN: begin
            if (dt_ff == '0) begin
               quo_in = '0;
            end else if (neg_ff) begin
               quo_in = 64'd0 - quo_ff;
            end
            state_in = ST_SUM_PI;
         end
         ST_SUM_PI: begin
            sum_in   = sat_add64({{16{p_ff[47]}}, p_ff}, iterm_ff);
            state_in = ST_SUM_D;
         end
         ST_SUM_D: begin
            sum_in   = sat_add64(sum_ff, $signed(quo_ff));
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            if (sum_ff >= 0) begin
               sum_in = sat_add64(sum_ff, bias64);
            end else begin
               sum_in = sat_add64(sum_ff, -bias64);
            end
            state_in = ST_DCLAMP;
         end
         ST_DCLAMP: begin
            if (dfloor_ff < dceil_ff) begin
               if (sum_ff < dfl64) begin
                  sum_in = dfl64;
               end else if (sum_ff > dce64) begin
                  sum_in = dce64;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               drive_in     = sat_to32(sum_ff);
               eout_in      = e_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mop_ff       <= MOP_P_HI;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         isum_ff      <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         mop_ff       <= mop_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         isum_ff      <= isum_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         ki_ff     <= '0;
         kd_ff     <= '0;
         ifloor_ff <= '0;
         iceil_ff  <= '0;
         dfloor_ff <= '0;
         dceil_ff  <= '0;
         bias_ff   <= '0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.reg_index))
            CSR_GAIN_P:        kp_ff     <= $signed(csr_bus.wdata[31:0]);
            CSR_GAIN_I:        ki_ff     <= $signed(csr_bus.wdata[31:0]);
            CSR_GAIN_D:        kd_ff     <= $signed(csr_bus.wdata[31:0]);
            CSR_INT_FLOOR:     ifloor_ff <= $signed(csr_bus.wdata[47:0]);
            CSR_INT_CEILING:   iceil_ff  <= $signed(csr_bus.wdata[47:0]);
            CSR_DRIVE_FLOOR:   dfloor_ff <= $signed(csr_bus.wdata[31:0]);
            CSR_DRIVE_CEILING: dceil_ff  <= $signed(csr_bus.wdata[31:0]);
            CSR_DRIVE_BIAS:    bias_ff   <= $signed(csr_bus.wdata[31:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      measured_ff <= measured_in;
      dt_ff       <= dt_in;
      eraw_ff     <= eraw_in;
      e_ff        <= e_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      iterm_ff    <= iterm_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      sum_ff      <= sum_in;
      drive_ff    <= drive_in;
      eout_ff     <= eout_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.drive     = drive_ff;
   assign rsp_bus.error_out = eout_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (state_ff == ST_SUBTRACT))
      else $error("Accepted request did not start the sequence.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_bus.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("Finished request did not reach the output register.");

   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ICLAMP && ifloor_ff < iceil_ff)
      |=> (isum_ff >= $past(ifloor_ff) && isum_ff <= $past(iceil_ff)))
      else $error("Integral sum left its clamp range.");

endmodule

`default_nettype wire
